// ===== rtl/odo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and tables for the wheel odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CW           = 34;   // CORDIC datapath width, Q2.30 plus guard
    localparam int CORDIC_STEPS = 30;
    localparam int AW           = 64;   // multiplier A operand width
    localparam int BW           = 34;   // multiplier B operand width
    localparam int PW           = AW + BW;
    localparam int DENW         = 30;   // divisor width (elapsed * 64)

    localparam logic signed [CW-1:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [BW-1:0] PER_RAD_SCALED = 34'sd5340354;
    localparam logic signed [BW-1:0] SPEED_SCALE    = 34'sd15625;

    localparam logic [31:0] DIST_PER_COUNT_RST = 32'd494130;
    localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd139735;

    typedef enum logic {
        REG_DIST_PER_COUNT = 1'b0,
        REG_INV_WHEEL_BASE = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MS_PROD  = 4'd0,
        MS_SFULL = 4'd1,
        MS_DX    = 4'd2,
        MS_DY    = 4'd3,
        MS_M     = 4'd4,
        MS_TURN  = 4'd5,
        MS_LIN   = 4'd6,
        MS_DIFFP = 4'd7,
        MS_ANG   = 4'd8
    } mstep_t;

    typedef struct packed {
        logic signed [CW-1:0] cos_val;
        logic signed [CW-1:0] sin_val;
    } trig_res_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // Round a Q2.30 value to Q1.15 and clamp to 16 bits.
    function automatic logic signed [15:0] sat_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        logic signed [15:0]   o;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            o = 16'sh7FFF;
        end else if (r < -34'sd32768) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

endpackage

// ===== rtl/odo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_mul
// Signed multiplier: 64 x 34 bits as two 64 x 17 partial products.
// ----------------------------------------------------------------------------
module odo_mul (
    input  logic                            aclk,
    input  logic                            en_lo,
    input  logic                            en_hi,
    input  logic signed [odo_pkg::AW-1:0]   a,
    input  logic signed [odo_pkg::BW-1:0]   b,
    output logic signed [odo_pkg::PW-1:0]   res
);
    import odo_pkg::*;

    logic signed [AW+17:0]  lo_prod;
    logic signed [AW+16:0]  hi_prod;
    logic signed [PW-1:0]   hi_ext;
    logic signed [PW-1:0]   acc_reg;

    assign lo_prod = a * $signed({1'b0, b[16:0]});
    assign hi_prod = a * $signed(b[BW-1:17]);
    assign hi_ext  = {hi_prod, 17'b0};

    always_ff @(posedge aclk) begin
        if (en_lo) begin
            acc_reg <= PW'(lo_prod);
        end else if (en_hi) begin
            acc_reg <= acc_reg + hi_ext;
        end
    end

    assign res = acc_reg;

endmodule

// ===== rtl/odo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, Q2.30 results.
// ----------------------------------------------------------------------------
module odo_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         angle,
    output logic                done,
    output odo_pkg::trig_res_t  res
);
    import odo_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] sh_x, sh_y, atan_v, z_in;
    logic [4:0]           iter_reg;
    logic                 flip_reg, busy_reg, done_reg, last;

    assign z_in   = CW'($signed(angle));
    assign sh_x   = x_reg >>> iter_reg;
    assign sh_y   = y_reg >>> iter_reg;
    assign atan_v = $signed({4'b0, atan_entry(iter_reg)});
    assign last   = (iter_reg == 5'(CORDIC_STEPS - 1));

    always_comb begin
        if (!z_reg[CW-1]) begin
            x_next = x_reg - sh_y;
            y_next = y_reg + sh_x;
            z_next = z_reg - atan_v;
        end else begin
            x_next = x_reg + sh_y;
            y_next = y_reg - sh_x;
            z_next = z_reg + atan_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            iter_reg <= '0;
            // fold the angle into the right half plane
            if (z_in > 34'sd1073741824) begin
                z_reg    <= z_in - 34'sd2147483648;
                flip_reg <= 1'b1;
            end else if (z_in < -34'sd1073741824) begin
                z_reg    <= z_in + 34'sd2147483648;
                flip_reg <= 1'b1;
            end else begin
                z_reg    <= z_in;
                flip_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            x_reg    <= (last && flip_reg) ? -x_next : x_next;
            y_reg    <= (last && flip_reg) ? -y_next : y_next;
            z_reg    <= z_next;
            iter_reg <= iter_reg + 5'd1;
        end
    end

    assign done        = done_reg;
    assign res.cos_val = x_reg;
    assign res.sin_val = y_reg;

endmodule

// ===== rtl/odo_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_div
// Restoring divider for speeds: rounds half away from zero, saturates to 32 bits.
// ----------------------------------------------------------------------------
module odo_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [63:0]          num,
    input  logic [odo_pkg::DENW-1:0]    den,
    output logic                        done,
    output logic [31:0]                 quot
);
    import odo_pkg::*;

    logic [63:0]     mag;
    logic [64:0]     nsum;
    logic            ovf;
    logic [DENW-1:0] rem_reg, den_reg;
    logic [32:0]     shf_reg, q_reg, q_fin;
    logic [5:0]      cnt_reg;
    logic            neg_reg, busy_reg, done_reg;
    logic [31:0]     quot_reg, sat_val;
    logic [DENW:0]   trial, diff;
    logic            ge;

    assign mag  = num[63] ? 64'(-num) : 64'(num);
    assign nsum = {1'b0, mag} + 65'(den >> 1);
    assign ovf  = (nsum[64:33] >= 32'(den));
    assign sat_val = num[63] ? 32'h80000000 : 32'h7FFFFFFF;

    assign trial = {rem_reg, shf_reg[32]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign q_fin = {q_reg[31:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num == '0 || den == '0 || ovf) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && cnt_reg == 6'd32) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= nsum[62:33];
            shf_reg <= nsum[32:0];
            q_reg   <= '0;
            cnt_reg <= '0;
            den_reg <= den;
            neg_reg <= num[63];
            if (num == '0) begin
                quot_reg <= '0;
            end else if (den == '0 || ovf) begin
                quot_reg <= sat_val;
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
            shf_reg <= {shf_reg[31:0], 1'b0};
            q_reg   <= q_fin;
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                if (!neg_reg) begin
                    quot_reg <= (q_fin > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_fin[31:0];
                end else begin
                    quot_reg <= (q_fin > 33'h080000000) ? 32'h80000000
                                                        : (~q_fin[31:0] + 32'd1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/diff_drive_encoder_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry_top
// Differential-drive wheel odometry: encoder words in, pose and speeds out.
// ----------------------------------------------------------------------------
// Each input word passes through two runs of the shared 30-step CORDIC (one
// for the old heading that steers the position update, one for the quaternion
// of the new heading), nine passes through the shared 64 x 34 multiplier (each
// through ST_MUL_LO, ST_MUL_HI and ST_MUL_WB), and two 33-step passes of the
// bit-serial divider for the speeds. A speed with a zero numerator, zero
// elapsed time or a quotient too wide for the 33-bit quotient register settles
// its divider pass at launch, without the bit-serial steps.
// s_ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next input word is taken while it is unread.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry_top #(
    parameter int WRAP_SPAN = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_wdata,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [11:0] s_left_raw,
    input  logic signed [11:0] s_right_raw,
    input  logic [23:0]        s_elapsed_us,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_x_pos,
    output logic signed [31:0] m_y_pos,
    output logic [31:0]        m_heading_angle,
    output logic signed [15:0] m_quat_z,
    output logic signed [15:0] m_quat_w,
    output logic signed [31:0] m_linear_velocity,
    output logic signed [31:0] m_angular_velocity
);
    import odo_pkg::*;

    // Step width: the raw difference spans +-4095, the unwrap adds a span.
    localparam int DW_MIN = $clog2(WRAP_SPAN) + 3;
    localparam int DW     = (DW_MIN > 14) ? DW_MIN : 14;
    localparam int SW     = DW + 1;
    localparam logic signed [DW-1:0] HALF = DW'(WRAP_SPAN / 2);
    localparam logic signed [DW-1:0] SPAN = DW'(WRAP_SPAN);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_TRIG   = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_MUL_WB = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t  st_reg;
    mstep_t  step_reg;
    logic    pass_reg, launch_reg;

    // configuration registers
    logic [31:0] dpc_reg;
    logic [23:0] ibase_reg;

    // wheel state
    logic signed [11:0] lprev_reg, rprev_reg;
    logic [31:0]        ltotal_reg, rtotal_reg;
    logic [31:0]        x_reg, y_reg, heading_reg;

    // per-word working registers
    logic signed [SW-1:0] sum_reg, diff_reg;
    logic [23:0]          elapsed_reg;
    logic signed [63:0]   sfull_reg, lin_num_reg, num2_reg;
    logic [55:0]          prod_reg;
    logic [53:0]          m_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;
    logic signed [15:0]   qz_reg, qw_reg;
    logic [31:0]          lin_reg;

    // output register
    logic                 m_valid_reg;
    logic signed [31:0]   ox_reg, oy_reg, olin_reg, oang_reg;
    logic [31:0]          ohead_reg;
    logic signed [15:0]   oqz_reg, oqw_reg;

    // ------------------------------------------------------------------
    // Step unwrap on the incoming word
    // ------------------------------------------------------------------
    logic signed [11:0]   left_now;
    logic signed [DW-1:0] dl_raw, dr_raw, dl, dr;
    logic                 s_fire, m_fire;

    assign left_now = -s_left_raw;   // wraps in 12 bits, so -2048 stays put
    assign dl_raw   = DW'(left_now) - DW'(lprev_reg);
    assign dr_raw   = DW'(s_right_raw) - DW'(rprev_reg);

    always_comb begin
        dl = dl_raw;
        if (dl_raw > HALF) begin
            dl = dl_raw - SPAN;
        end else if (dl_raw < -HALF) begin
            dl = dl_raw + SPAN;
        end
        dr = dr_raw;
        if (dr_raw > HALF) begin
            dr = dr_raw - SPAN;
        end else if (dr_raw < -HALF) begin
            dr = dr_raw + SPAN;
        end
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by step
    // ------------------------------------------------------------------
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_res;
    logic signed [63:0]   s20, s8;
    logic [56:0]          p16_sum, p20_sum;
    logic [40:0]          p16;
    logic [36:0]          p20;

    assign s20     = (sfull_reg + 64'sd2048) >>> 12;
    assign s8      = (sfull_reg + 64'sd128) >>> 8;
    assign p16_sum = 57'(prod_reg) + 57'd32768;
    assign p20_sum = 57'(prod_reg) + 57'd524288;
    assign p16     = p16_sum[56:16];
    assign p20     = p20_sum[56:20];

    always_comb begin
        unique case (step_reg)
            MS_PROD: begin
                mul_a = $signed({32'b0, dpc_reg});
                mul_b = $signed({10'b0, ibase_reg});
            end
            MS_SFULL: begin
                mul_a = $signed({32'b0, dpc_reg});
                mul_b = BW'(sum_reg);
            end
            MS_DX: begin
                mul_a = s20;
                mul_b = cos_reg;
            end
            MS_DY: begin
                mul_a = s20;
                mul_b = sin_reg;
            end
            MS_M: begin
                mul_a = $signed({23'b0, p16});
                mul_b = PER_RAD_SCALED;
            end
            MS_TURN: begin
                mul_a = $signed({10'b0, m_reg});
                mul_b = BW'(diff_reg);
            end
            MS_LIN: begin
                mul_a = s8;
                mul_b = SPEED_SCALE;
            end
            MS_DIFFP: begin
                mul_a = $signed({27'b0, p20});
                mul_b = BW'(diff_reg);
            end
            MS_ANG: begin
                mul_a = num2_reg;
                mul_b = SPEED_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    odo_mul u_mul (
        .aclk  (aclk),
        .en_lo (st_reg == ST_MUL_LO),
        .en_hi (st_reg == ST_MUL_HI),
        .a     (mul_a),
        .b     (mul_b),
        .res   (mul_res)
    );

    // rounded write-back values
    logic signed [PW-1:0] r35;
    logic [63:0]          m_sum, t_sum;

    assign r35   = mul_res + {63'b0, 1'b1, 34'b0};
    assign m_sum = mul_res[63:0] + 64'd512;
    assign t_sum = mul_res[63:0] + 64'd32768;

    // ------------------------------------------------------------------
    // Shared CORDIC and divider
    // ------------------------------------------------------------------
    trig_res_t trig_res;
    logic      trig_done, div_done;
    logic [31:0] div_quot;

    odo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (launch_reg && st_reg == ST_TRIG),
        .angle   (pass_reg ? heading_reg : {heading_reg[30:0], 1'b0}),
        .done    (trig_done),
        .res     (trig_res)
    );

    odo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (launch_reg && st_reg == ST_DIV),
        .num     (pass_reg ? num2_reg : lin_num_reg),
        .den     (pass_reg ? {elapsed_reg, 6'b0} : {3'b0, elapsed_reg, 3'b0}),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            step_reg   <= MS_PROD;
            pass_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end else begin
            launch_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        st_reg     <= ST_TRIG;
                        pass_reg   <= 1'b0;
                        launch_reg <= 1'b1;
                    end
                end
                ST_TRIG: begin
                    if (trig_done) begin
                        st_reg   <= ST_MUL_LO;
                        step_reg <= pass_reg ? MS_LIN : MS_PROD;
                    end
                end
                ST_MUL_LO: st_reg <= ST_MUL_HI;
                ST_MUL_HI: st_reg <= ST_MUL_WB;
                ST_MUL_WB: begin
                    st_reg <= ST_MUL_LO;
                    unique case (step_reg)
                        MS_PROD:  step_reg <= MS_SFULL;
                        MS_SFULL: step_reg <= MS_DX;
                        MS_DX:    step_reg <= MS_DY;
                        MS_DY:    step_reg <= MS_M;
                        MS_M:     step_reg <= MS_TURN;
                        MS_TURN: begin
                            // new heading ready: run the quaternion pass
                            st_reg     <= ST_TRIG;
                            pass_reg   <= 1'b1;
                            launch_reg <= 1'b1;
                        end
                        MS_LIN:   step_reg <= MS_DIFFP;
                        MS_DIFFP: step_reg <= MS_ANG;
                        MS_ANG: begin
                            st_reg     <= ST_DIV;
                            pass_reg   <= 1'b0;
                            launch_reg <= 1'b1;
                        end
                        default:  step_reg <= MS_PROD;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (pass_reg) begin
                            st_reg <= ST_DONE;
                        end else begin
                            pass_reg   <= 1'b1;
                            launch_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Configuration, wheel state and pose
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpc_reg     <= DIST_PER_COUNT_RST;
            ibase_reg   <= INV_WHEEL_BASE_RST;
            lprev_reg   <= '0;
            rprev_reg   <= '0;
            ltotal_reg  <= '0;
            rtotal_reg  <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            heading_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_DIST_PER_COUNT: dpc_reg   <= cfg_wdata;
                    REG_INV_WHEEL_BASE: ibase_reg <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_fire) begin
                lprev_reg  <= left_now;
                rprev_reg  <= s_right_raw;
                ltotal_reg <= ltotal_reg + 32'(dl);
                rtotal_reg <= rtotal_reg + 32'(dr);
            end
            if (st_reg == ST_MUL_WB) begin
                unique case (step_reg)
                    MS_DX:   x_reg       <= x_reg + r35[66:35];
                    MS_DY:   y_reg       <= y_reg + r35[66:35];
                    MS_TURN: heading_reg <= heading_reg + t_sum[47:16];
                    default: ;
                endcase
            end
        end
    end

    // per-word datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sum_reg     <= SW'(dl) + SW'(dr);
            diff_reg    <= SW'(dr) - SW'(dl);
            elapsed_reg <= s_elapsed_us;
        end
        if (st_reg == ST_TRIG && trig_done) begin
            if (pass_reg) begin
                qz_reg <= sat_q15(trig_res.sin_val);
                qw_reg <= sat_q15(trig_res.cos_val);
            end else begin
                cos_reg <= trig_res.cos_val;
                sin_reg <= trig_res.sin_val;
            end
        end
        if (st_reg == ST_MUL_WB) begin
            unique case (step_reg)
                MS_PROD:  prod_reg    <= mul_res[55:0];
                MS_SFULL: sfull_reg   <= mul_res[63:0];
                MS_M:     m_reg       <= m_sum[63:10];
                MS_LIN:   lin_num_reg <= mul_res[63:0];
                MS_DIFFP: num2_reg    <= mul_res[63:0];
                MS_ANG:   num2_reg    <= mul_res[63:0];
                default: ;
            endcase
        end
        if (st_reg == ST_DIV && div_done && !pass_reg) begin
            lin_reg <= div_quot;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic load_out;
    assign load_out = (st_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            ox_reg    <= x_reg;
            oy_reg    <= y_reg;
            ohead_reg <= heading_reg;
            oqz_reg   <= qz_reg;
            oqw_reg   <= qw_reg;
            olin_reg  <= lin_reg;
            oang_reg  <= div_quot;
        end
    end

    // angular speed is still on the divider output in ST_DONE
    assign m_valid            = m_valid_reg;
    assign m_x_pos            = ox_reg;
    assign m_y_pos            = oy_reg;
    assign m_heading_angle    = ohead_reg;
    assign m_quat_z           = oqz_reg;
    assign m_quat_w           = oqw_reg;
    assign m_linear_velocity  = olin_reg;
    assign m_angular_velocity = oang_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted twice without finishing a word");

    a_trig_done_in_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        trig_done |-> st_reg == ST_TRIG)
        else $error("CORDIC finished outside its sequencer state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> st_reg == ST_DIV)
        else $error("divider finished outside its sequencer state");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_reg == ST_DONE))
        else $error("result word raised without a finished computation");

endmodule

// ===== dv/odo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_checker
// Watches the input and result channels of the odometry block, predicts each
// result word from the accepted input words and compares field by field.
// ----------------------------------------------------------------------------
module odo_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [11:0] s_left_raw,
    input  logic signed [11:0] s_right_raw,
    input  logic [23:0]        s_elapsed_us,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_x_pos,
    input  logic signed [31:0] m_y_pos,
    input  logic [31:0]        m_heading_angle,
    input  logic signed [15:0] m_quat_z,
    input  logic signed [15:0] m_quat_w,
    input  logic signed [31:0] m_linear_velocity,
    input  logic signed [31:0] m_angular_velocity,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    import odo_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] hd;
        logic [15:0] qz;
        logic [15:0] qw;
        logic [31:0] lin;
        logic [31:0] ang;
    } pose_word_t;

    pose_word_t pose_q[$];

    logic [31:0] dpc;
    logic [23:0] iwb;
    logic signed [11:0] left_last, right_last;
    logic [31:0] left_total, right_total;
    logic [31:0] px, py, phd;

    longint arctan[30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic int step_count(int now, int prev);
        int d;
        d = now - prev;
        if (d > 1024) d -= 2048;
        else if (d < -1024) d += 2048;
        return d;
    endfunction

    // angle: full 32-bit turn is 2*pi; results Q2.30
    task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
        longint z, xv, yv, tx;
        bit flip;
        z = angle;
        xv = 652032874;
        yv = 0;
        flip = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            tx = xv;
            if (z >= 0) begin
                xv -= yv >>> i;
                yv += tx >>> i;
                z -= arctan[i];
            end else begin
                xv += yv >>> i;
                yv -= tx >>> i;
                z += arctan[i];
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endtask

    function automatic logic [31:0] speed_quot(longint num, longint den);
        longint mag, q;
        if (num == 0) return 0;
        if (den == 0) return num > 0 ? 32'h7FFFFFFF : 32'h80000000;
        mag = num > 0 ? num : -num;
        q = (mag + den / 2) / den;
        if (num > 0) return q > 64'sh7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
        return q > 64'sh80000000 ? 32'h80000000 : 32'(-q);
    endfunction

    function automatic logic [15:0] clamp_q15(longint v);
        longint r;
        r = round_shift(v, 15);
        if (r > 32767) return 16'h7FFF;
        if (r < -32768) return 16'h8000;
        return r[15:0];
    endfunction

    task automatic advance_pose(input logic signed [11:0] lraw,
                                input logic signed [11:0] rraw,
                                input logic [23:0] el);
        logic signed [11:0] lnow;
        int dl, dr;
        longint sum, diff, sfull, s20, c, s, qc, qs, elapsed;
        logic [63:0] prod, p16, m, turn, p20;
        pose_word_t w;
        lnow = -lraw;  // wraps: -2048 stays -2048
        dl = step_count(lnow, left_last);
        dr = step_count(rraw, right_last);
        left_last = lnow;
        right_last = rraw;
        left_total += dl;
        right_total += dr;
        sum = dl + dr;
        diff = dr - dl;
        elapsed = el;
        sfull = sum * longint'(dpc);
        s20 = round_shift(sfull, 12);
        rotate({phd[30:0], 1'b0}, c, s);
        px += 32'(round_shift(s20 * c, 35));
        py += 32'(round_shift(s20 * s, 35));
        prod = 64'(dpc) * 64'(iwb);
        p16 = (prod + 32768) >> 16;
        m = (p16 * 5340354 + 512) >> 10;
        turn = (64'(diff) * m + 32768) >> 16;
        phd += turn[31:0];
        rotate(phd, qc, qs);
        p20 = (prod + 524288) >> 20;
        w.x = px;
        w.y = py;
        w.hd = phd;
        w.qz = clamp_q15(qs);
        w.qw = clamp_q15(qc);
        w.lin = speed_quot(round_shift(sfull, 8) * 15625, elapsed * 8);
        w.ang = speed_quot(diff * longint'(p20) * 15625, elapsed * 64);
        pose_q.push_back(w);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pose_word_t e;
        if (!aresetn) begin
            dpc <= DIST_PER_COUNT_RST;
            iwb <= INV_WHEEL_BASE_RST;
            left_last = 0;
            right_last = 0;
            left_total = 0;
            right_total = 0;
            px = 0;
            py = 0;
            phd = 0;
            pose_q.delete();
            fail_count = 0;
            result_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_DIST_PER_COUNT) dpc <= cfg_wdata;
                else iwb <= cfg_wdata[23:0];
            end
            if (s_valid && s_ready) advance_pose(s_left_raw, s_right_raw, s_elapsed_us);
            if (m_valid && m_ready) begin
                result_count++;
                if (pose_q.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    fail_count++;
                end else begin
                    e = pose_q.pop_front();
                    check_field("x_pos", e.x, m_x_pos);
                    check_field("y_pos", e.y, m_y_pos);
                    check_field("heading", e.hd, m_heading_angle);
                    check_field("quat_z", {16'h0, e.qz}, {16'h0, m_quat_z});
                    check_field("quat_w", {16'h0, e.qw}, {16'h0, m_quat_w});
                    check_field("lin_vel", e.lin, m_linear_velocity);
                    check_field("ang_vel", e.ang, m_angular_velocity);
                end
            end
        end
        pending = pose_q.size();
    end
endmodule

// ===== dv/tb_diff_drive_encoder_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_encoder_odometry_top
// Drives encoder words and register writes into the odometry block under
// bursty input and stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_diff_drive_encoder_odometry_top;
    import odo_pkg::*;

    localparam int LATENCY = 200;
    localparam int CYCLE_LIMIT = 900000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    cfg_reg_t cfg_addr = REG_DIST_PER_COUNT;
    logic [31:0] cfg_wdata = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [11:0] s_left_raw = 0;
    logic signed [11:0] s_right_raw = 0;
    logic [23:0] s_elapsed_us = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_x_pos, m_y_pos, m_linear_velocity, m_angular_velocity;
    logic [31:0] m_heading_angle;
    logic signed [15:0] m_quat_z, m_quat_w;

    int fail_count, pending, result_count;
    int cycles = 0;
    int word_count = 0;
    bit long_hold = 0;
    bit running = 1;

    // keep the encoder readings as a wheel would produce them
    logic signed [11:0] left_pos = 0, right_pos = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    diff_drive_encoder_odometry_top u_dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_left_raw, .s_right_raw, .s_elapsed_us,
        .m_valid, .m_ready, .m_x_pos, .m_y_pos, .m_heading_angle,
        .m_quat_z, .m_quat_w, .m_linear_velocity, .m_angular_velocity
    );

    odo_checker u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_left_raw, .s_right_raw, .s_elapsed_us,
        .m_valid, .m_ready, .m_x_pos, .m_y_pos, .m_heading_angle,
        .m_quat_z, .m_quat_w, .m_linear_velocity, .m_angular_velocity,
        .fail_count, .pending, .result_count
    );

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: stall on its own pattern; a long hold-off when asked.
    always @(posedge aclk) begin
        int mode;
        mode = (cycles / 3000) % 3;
        if (long_hold) m_ready <= 0;
        else if (mode == 0) m_ready <= 1;
        else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 9) < 3);
    end

    // Offer one word and hold it until accepted.
    task automatic send_word(input logic signed [11:0] l, input logic signed [11:0] r,
                             input logic [23:0] el);
        s_valid <= 1;
        s_left_raw <= l;
        s_right_raw <= r;
        s_elapsed_us <= el;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        word_count++;
    endtask

    task automatic go_idle();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        go_idle();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    // Advance both wheels by random steps; mostly small moves, sometimes jumps of up
    // to half the span or fresh random readings, so the unwrap sees every case.
    task automatic random_word();
        int kind;
        logic [23:0] el;
        logic signed [11:0] lr, rr;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            left_pos += 12'($urandom_range(0, 80) - 40);
            right_pos += 12'($urandom_range(0, 80) - 40);
        end else if (kind < 8) begin
            left_pos += 12'($urandom_range(0, 2048) - 1024);
            right_pos += 12'($urandom_range(0, 2048) - 1024);
        end else begin
            left_pos = 12'($urandom);
            right_pos = 12'($urandom);
        end
        case ($urandom_range(0, 7))
            0: el = 0;
            1: el = 24'($urandom);
            2: el = 24'hFFFFFF;
            default: el = 24'($urandom_range(1000, 20000));
        endcase
        lr = -left_pos;
        rr = right_pos;
        send_word(lr, rr, el);
    endtask

    task automatic random_phase(input int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n; i++) begin
                random_word();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                go_idle();
                repeat ($urandom_range(0, 400)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, exact half-span step, negating -2048,
        // wraps both ways and zero elapsed time.
        send_word(12'sd0, 12'sd0, 24'd0);
        send_word(12'sh400, 12'sh400, 24'd10000);
        send_word(-12'sd1024, 12'sh7FF, 24'd10000);
        send_word(12'sh800, 12'sh800, 24'd0);
        send_word(12'sh7FF, 12'sh800, 24'hFFFFFF);
        send_word(12'sh800, 12'sh7FF, 24'd1);
        send_word(12'sd100, -12'sd100, 24'd5000);
        send_word(-12'sd100, 12'sd100, 24'd0);
        send_word(12'h555, 12'hAAA, 24'h555555);
        send_word(12'hAAA, 12'h555, 24'hAAAAAA);
        drain();  // sender pauses until every result has come
        left_pos = 0;
        right_pos = 0;
        send_word(12'sd0, 12'sd0, 24'd1000);
        drain();

        // Long receiver hold-off while the sender keeps offering words.
        fork
            begin
                long_hold = 1;
                repeat (3000) @(posedge aclk);
                long_hold = 0;
            end
            random_phase(20);
        join
        drain();

        random_phase(250);
        drain();

        // Extreme register settings, then back to typical ones.
        write_reg(REG_DIST_PER_COUNT, 32'hFFFFFFFF);
        write_reg(REG_INV_WHEEL_BASE, 32'h00FFFFFF);
        random_phase(60);
        drain();
        write_reg(REG_DIST_PER_COUNT, 32'd0);
        write_reg(REG_INV_WHEEL_BASE, 32'd0);
        random_phase(40);
        drain();
        write_reg(REG_DIST_PER_COUNT, $urandom);
        write_reg(REG_INV_WHEEL_BASE, {8'h00, 24'($urandom)});
        random_phase(200);
        drain();
        write_reg(REG_DIST_PER_COUNT, 32'd1000000);
        write_reg(REG_INV_WHEEL_BASE, 32'd200000);
        random_phase(300);
        drain();

        $display("run covered %0d input words and %0d result words", word_count, result_count);
        $display("register extremes, wrap steps, zero and maximum elapsed time exercised");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/odo_pkg.sv
rtl/odo_mul.sv
rtl/odo_cordic.sv
rtl/odo_div.sv
rtl/diff_drive_encoder_odometry_top.sv
dv/odo_checker.sv
dv/tb_diff_drive_encoder_odometry_top.sv
